>>> rtl/sorted_key_table_top_macros.svh
// assertion macros used by the sorted key table top
`ifndef SORTED_KEY_TABLE_TOP_MACROS_SVH
`define SORTED_KEY_TABLE_TOP_MACROS_SVH

// same-cycle implication
`define SKT_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SKT_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/skt_pkg.sv
// types and constants of the sorted key table
package skt_pkg;

    localparam int CAPACITY = 64;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int KEY_W    = 32;
    localparam int DATA_W   = 64;
    localparam int ECNT_W   = 7;
    localparam int GRP_SZ   = 8;
    localparam int NGRP     = (CAPACITY + GRP_SZ - 1) / GRP_SZ;

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_INSERT = 2'd1,
        OP_MODIFY = 2'd2,
        OP_DELETE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_EXISTS  = 2'd1,
        STAT_FULL    = 2'd2,
        STAT_MISSING = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_UPD,
        S_DONE
    } state_t;

    typedef struct packed {
        logic cmp;
        logic ins;
        logic del;
        logic mod;
    } cmd_t;

endpackage

>>> rtl/sorted_key_table_top.sv
// sorted key table: a row of slot cells kept in ascending key order
// a request word is taken in idle and passes the compare, update and done states; the result word is registered in done
// one request word at a time (compare, update, collect, then idle); collect waits while the result word is held
// the compare and shift run in all cells at once; payload collection is a two-level or tree
// reset (aresetn low, synchronous) empties the table and drops the result valid
`include "sorted_key_table_top_macros.svh"

module sorted_key_table_top (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [1:0]                  s_opcode,
    input  logic [skt_pkg::KEY_W-1:0]   s_key,
    input  logic [skt_pkg::DATA_W-1:0]  s_entry_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [1:0]                  m_status,
    output logic [skt_pkg::DATA_W-1:0]  m_read_data,
    output logic [skt_pkg::ECNT_W-1:0]  m_entry_count
);

    skt_pkg::state_t               state_reg, state_next;
    skt_pkg::op_t                  op_reg;
    logic [skt_pkg::KEY_W-1:0]     key_reg;
    logic [skt_pkg::DATA_W-1:0]    data_reg;
    logic [skt_pkg::CNT_W-1:0]     count_reg, count_next;
    skt_pkg::status_t              status_reg, status_next;
    logic                          m_valid_reg;
    logic [1:0]                    m_status_reg;
    logic [skt_pkg::DATA_W-1:0]    m_read_data_reg;
    logic [skt_pkg::ECNT_W-1:0]    m_entry_count_reg;
    logic [skt_pkg::DATA_W-1:0]    grp_reg [skt_pkg::NGRP];
    logic [skt_pkg::DATA_W-1:0]    grp_next [skt_pkg::NGRP];
    logic [skt_pkg::DATA_W-1:0]    rd_sum;

    skt_pkg::cmd_t                 cmd;
    logic [skt_pkg::CAPACITY-1:0]  occ_vec;
    logic [skt_pkg::CAPACITY-1:0]  sel_vec;
    logic [skt_pkg::CAPACITY-1:0]  eq_vec;
    logic [skt_pkg::KEY_W-1:0]     key_vec  [skt_pkg::CAPACITY];
    logic [skt_pkg::DATA_W-1:0]    data_vec [skt_pkg::CAPACITY];
    logic [skt_pkg::DATA_W-1:0]    hit_vec  [skt_pkg::CAPACITY];
    logic                          hit;
    logic                          full;
    logic                          out_load;

    assign hit  = |eq_vec;
    assign full = (count_reg == skt_pkg::CNT_W'(skt_pkg::CAPACITY));

    always_comb begin
        for (int i = 0; i < skt_pkg::CAPACITY; i++) begin
            occ_vec[i] = (skt_pkg::CNT_W'(i) < count_reg);
        end
    end

    // cell row
    for (genvar i = 0; i < skt_pkg::CAPACITY; i++) begin : g_cell
        logic                       lo_sel;
        logic [skt_pkg::KEY_W-1:0]  lo_key;
        logic [skt_pkg::DATA_W-1:0] lo_data;
        logic [skt_pkg::KEY_W-1:0]  hi_key;
        logic [skt_pkg::DATA_W-1:0] hi_data;

        if (i == 0) begin : g_first
            assign lo_sel  = 1'b0;
            assign lo_key  = '0;
            assign lo_data = '0;
        end else begin : g_mid_lo
            assign lo_sel  = sel_vec[i-1];
            assign lo_key  = key_vec[i-1];
            assign lo_data = data_vec[i-1];
        end

        if (i == skt_pkg::CAPACITY - 1) begin : g_last
            assign hi_key  = '0;
            assign hi_data = '0;
        end else begin : g_mid_hi
            assign hi_key  = key_vec[i+1];
            assign hi_data = data_vec[i+1];
        end

        skt_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .cmd        (cmd),
            .occ        (occ_vec[i]),
            .req_key    (key_reg),
            .req_data   (data_reg),
            .lo_sel     (lo_sel),
            .lo_key     (lo_key),
            .lo_data    (lo_data),
            .hi_key     (hi_key),
            .hi_data    (hi_data),
            .key_q      (key_vec[i]),
            .data_q     (data_vec[i]),
            .sel_q      (sel_vec[i]),
            .eq_q       (eq_vec[i]),
            .hit_data_q (hit_vec[i])
        );
    end

    // first level of the payload or tree
    always_comb begin
        for (int g = 0; g < skt_pkg::NGRP; g++) begin
            grp_next[g] = '0;
            for (int j = 0; j < skt_pkg::GRP_SZ; j++) begin
                if (g * skt_pkg::GRP_SZ + j < skt_pkg::CAPACITY) begin
                    grp_next[g] = grp_next[g] | hit_vec[g * skt_pkg::GRP_SZ + j];
                end
            end
        end
    end

    always_comb begin
        rd_sum = '0;
        for (int g = 0; g < skt_pkg::NGRP; g++) begin
            rd_sum = rd_sum | grp_reg[g];
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == skt_pkg::S_UPD) begin
            for (int g = 0; g < skt_pkg::NGRP; g++) begin
                grp_reg[g] <= grp_next[g];
            end
        end
    end

    assign out_load = (state_reg == skt_pkg::S_DONE) && (!m_valid_reg || m_ready);

    // control
    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        status_next = status_reg;
        cmd         = '0;
        case (state_reg)
            skt_pkg::S_IDLE: begin
                if (s_valid) begin
                    state_next = skt_pkg::S_CMP;
                end
            end
            skt_pkg::S_CMP: begin
                cmd.cmp    = 1'b1;
                state_next = skt_pkg::S_UPD;
            end
            skt_pkg::S_UPD: begin
                state_next  = skt_pkg::S_DONE;
                status_next = skt_pkg::STAT_OK;
                case (op_reg)
                    skt_pkg::OP_INSERT: begin
                        if (hit) begin
                            status_next = skt_pkg::STAT_EXISTS;
                        end else if (full) begin
                            status_next = skt_pkg::STAT_FULL;
                        end else begin
                            cmd.ins    = 1'b1;
                            count_next = count_reg + 1'b1;
                        end
                    end
                    skt_pkg::OP_DELETE: begin
                        if (hit) begin
                            cmd.del    = 1'b1;
                            count_next = count_reg - 1'b1;
                        end else begin
                            status_next = skt_pkg::STAT_MISSING;
                        end
                    end
                    skt_pkg::OP_MODIFY: begin
                        if (hit) begin
                            cmd.mod = 1'b1;
                        end else begin
                            status_next = skt_pkg::STAT_MISSING;
                        end
                    end
                    default: begin
                        if (!hit) begin
                            status_next = skt_pkg::STAT_MISSING;
                        end
                    end
                endcase
            end
            skt_pkg::S_DONE: begin
                if (out_load) begin
                    state_next = skt_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = skt_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= skt_pkg::S_IDLE;
            count_reg   <= '0;
            status_reg  <= skt_pkg::STAT_OK;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            status_reg <= status_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // request and result words
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg   <= skt_pkg::op_t'(s_opcode);
            key_reg  <= s_key;
            data_reg <= s_entry_data;
        end
        if (out_load) begin
            m_status_reg      <= status_reg;
            m_read_data_reg   <= (op_reg == skt_pkg::OP_LOOKUP) ? rd_sum : '0;
            m_entry_count_reg <= skt_pkg::ECNT_W'(count_reg);
        end
    end

    assign s_ready       = (state_reg == skt_pkg::S_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_read_data   = m_read_data_reg;
    assign m_entry_count = m_entry_count_reg;

    `SKT_ASSERT_NOW(a_count_range, aclk, aresetn, 1'b1,
        count_reg <= skt_pkg::CNT_W'(skt_pkg::CAPACITY), "fill count above capacity")
    `SKT_ASSERT_NOW(a_eq_single, aclk, aresetn, state_reg == skt_pkg::S_UPD,
        $onehot0(eq_vec), "more than one slot matches the key")
    `SKT_ASSERT_NOW(a_sel_monotonic, aclk, aresetn, state_reg == skt_pkg::S_UPD,
        ((sel_vec << 1) & ~sel_vec) == '0, "slot order broken")
    `SKT_ASSERT_NEXT(a_insert_count, aclk, aresetn, cmd.ins,
        count_reg == $past(count_reg) + 1'b1, "insert did not grow the table")
    `SKT_ASSERT_NEXT(a_delete_count, aclk, aresetn, cmd.del,
        count_reg == $past(count_reg) - 1'b1, "delete did not shrink the table")

endmodule

>>> rtl/skt_cell.sv
// one table slot: holds a key and payload, compares and shifts with its neighbors
module skt_cell (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  skt_pkg::cmd_t              cmd,
    input  logic                       occ,
    input  logic [skt_pkg::KEY_W-1:0]  req_key,
    input  logic [skt_pkg::DATA_W-1:0] req_data,
    input  logic                       lo_sel,
    input  logic [skt_pkg::KEY_W-1:0]  lo_key,
    input  logic [skt_pkg::DATA_W-1:0] lo_data,
    input  logic [skt_pkg::KEY_W-1:0]  hi_key,
    input  logic [skt_pkg::DATA_W-1:0] hi_data,
    output logic [skt_pkg::KEY_W-1:0]  key_q,
    output logic [skt_pkg::DATA_W-1:0] data_q,
    output logic                       sel_q,
    output logic                       eq_q,
    output logic [skt_pkg::DATA_W-1:0] hit_data_q
);

    logic [skt_pkg::KEY_W-1:0]  key_reg;
    logic [skt_pkg::DATA_W-1:0] data_reg;
    logic [skt_pkg::DATA_W-1:0] hit_data_reg;
    logic                       sel_reg;
    logic                       eq_reg;
    logic                       eq_now;

    assign eq_now = occ && (key_reg == req_key);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sel_reg <= 1'b0;
            eq_reg  <= 1'b0;
        end else if (cmd.cmp) begin
            sel_reg <= !occ || (key_reg >= req_key);
            eq_reg  <= eq_now;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.cmp) begin
            hit_data_reg <= eq_now ? data_reg : '0;
        end
        if (cmd.ins) begin
            if (lo_sel) begin
                key_reg  <= lo_key;
                data_reg <= lo_data;
            end else if (sel_reg) begin
                key_reg  <= req_key;
                data_reg <= req_data;
            end
        end else if (cmd.del) begin
            if (sel_reg) begin
                key_reg  <= hi_key;
                data_reg <= hi_data;
            end
        end else if (cmd.mod) begin
            if (eq_reg) begin
                data_reg <= req_data;
            end
        end
    end

    assign key_q      = key_reg;
    assign data_q     = data_reg;
    assign sel_q      = sel_reg;
    assign eq_q       = eq_reg;
    assign hit_data_q = hit_data_reg;

endmodule

>>> tb/skt_table_checker.sv
// checker for the sorted key table: tracks the table contents and compares every result word
`timescale 1ns / 100ps

module skt_table_checker (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    input  logic                        s_ready,
    input  logic [1:0]                  s_opcode,
    input  logic [skt_pkg::KEY_W-1:0]   s_key,
    input  logic [skt_pkg::DATA_W-1:0]  s_entry_data,
    input  logic                        m_valid,
    input  logic                        m_ready,
    input  logic [1:0]                  m_status,
    input  logic [skt_pkg::DATA_W-1:0]  m_read_data,
    input  logic [skt_pkg::ECNT_W-1:0]  m_entry_count,
    output int                          fail_count,
    output int                          awaiting_replies
);

    typedef struct packed {
        logic [1:0]                  status;
        logic [skt_pkg::DATA_W-1:0]  read_data;
        logic [skt_pkg::ECNT_W-1:0]  entry_count;
    } table_reply_t;

    logic [skt_pkg::KEY_W-1:0]   slot_key  [skt_pkg::CAPACITY];
    logic [skt_pkg::DATA_W-1:0]  slot_data [skt_pkg::CAPACITY];
    int                          held;
    int                          errors;
    table_reply_t                expected_replies [$];

    function automatic table_reply_t apply_request(skt_pkg::op_t op,
                                                   logic [skt_pkg::KEY_W-1:0] k,
                                                   logic [skt_pkg::DATA_W-1:0] d);
        int           pos;
        bit           hit;
        bit           found;
        table_reply_t r;
        pos = held;
        hit = 1'b0;
        found = 1'b0;
        for (int i = 0; i < held; i++) begin
            if (!found && slot_key[i] >= k) begin
                found = 1'b1;
                pos = i;
                hit = (slot_key[i] == k);
            end
        end
        r.status = skt_pkg::STAT_OK;
        r.read_data = '0;
        case (op)
            skt_pkg::OP_LOOKUP: begin
                if (hit) begin
                    r.read_data = slot_data[pos];
                end else begin
                    r.status = skt_pkg::STAT_MISSING;
                end
            end
            skt_pkg::OP_INSERT: begin
                if (hit) begin
                    r.status = skt_pkg::STAT_EXISTS;
                end else if (held >= skt_pkg::CAPACITY) begin
                    r.status = skt_pkg::STAT_FULL;
                end else begin
                    for (int i = held; i > pos; i--) begin
                        slot_key[i] = slot_key[i-1];
                        slot_data[i] = slot_data[i-1];
                    end
                    slot_key[pos] = k;
                    slot_data[pos] = d;
                    held++;
                end
            end
            skt_pkg::OP_MODIFY: begin
                if (hit) begin
                    slot_data[pos] = d;
                end else begin
                    r.status = skt_pkg::STAT_MISSING;
                end
            end
            default: begin
                if (hit) begin
                    for (int i = pos; i + 1 < held; i++) begin
                        slot_key[i] = slot_key[i+1];
                        slot_data[i] = slot_data[i+1];
                    end
                    held--;
                end else begin
                    r.status = skt_pkg::STAT_MISSING;
                end
            end
        endcase
        r.entry_count = skt_pkg::ECNT_W'(held);
        return r;
    endfunction

    always @(posedge aclk) begin : watch
        table_reply_t want;
        if (!aresetn) begin
            expected_replies.delete();
            held = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_replies.size() == 0) begin
                    $display("%0t: unexpected result word, expected none actual status %0d",
                             $time, m_status);
                    errors++;
                end else begin
                    want = expected_replies.pop_front();
                    if (m_status !== want.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, m_status);
                        errors++;
                    end
                    if (m_read_data !== want.read_data) begin
                        $display("%0t: read_data expected %h actual %h",
                                 $time, want.read_data, m_read_data);
                        errors++;
                    end
                    if (m_entry_count !== want.entry_count) begin
                        $display("%0t: entry_count expected %0d actual %0d",
                                 $time, want.entry_count, m_entry_count);
                        errors++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                expected_replies.push_back(
                    apply_request(skt_pkg::op_t'(s_opcode), s_key, s_entry_data));
            end
        end
        fail_count <= errors;
        awaiting_replies <= expected_replies.size();
    end

endmodule

>>> tb/tb_sorted_key_table_top.sv
// testbench top for the sorted key table: request stimulus, result back-pressure and verdict
`timescale 1ns / 100ps

module tb_sorted_key_table_top;

    logic                           aclk;
    logic                           aresetn = 1'b0;
    logic                           s_valid = 1'b0;
    logic                           s_ready;
    logic [1:0]                     s_opcode = 2'd0;
    logic [skt_pkg::KEY_W-1:0]      s_key = '0;
    logic [skt_pkg::DATA_W-1:0]     s_entry_data = '0;
    logic                           m_valid;
    logic                           m_ready = 1'b0;
    logic [1:0]                     m_status;
    logic [skt_pkg::DATA_W-1:0]     m_read_data;
    logic [skt_pkg::ECNT_W-1:0]     m_entry_count;
    int                             fail_count;
    int                             awaiting_replies;
    bit                             quiet = 1'b0;

    sorted_key_table_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_opcode      (s_opcode),
        .s_key         (s_key),
        .s_entry_data  (s_entry_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_read_data   (m_read_data),
        .m_entry_count (m_entry_count)
    );

    skt_table_checker u_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_opcode         (s_opcode),
        .s_key            (s_key),
        .s_entry_data     (s_entry_data),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_read_data      (m_read_data),
        .m_entry_count    (m_entry_count),
        .fail_count       (fail_count),
        .awaiting_replies (awaiting_replies)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("sorted_key_table_top test failed");
        $finish;
    end

    function automatic logic [skt_pkg::KEY_W-1:0] pool_key(int idx,
                                                           logic [skt_pkg::KEY_W-1:0] mask);
        return (skt_pkg::KEY_W'(idx) * 32'h9E3779B1) ^ mask;
    endfunction

    function automatic logic [skt_pkg::DATA_W-1:0] rand_data();
        return {$urandom, $urandom};
    endfunction

    task automatic send_request(skt_pkg::op_t op, logic [skt_pkg::KEY_W-1:0] k,
                                logic [skt_pkg::DATA_W-1:0] d);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_opcode <= op;
        s_key <= k;
        s_entry_data <= d;
        do @(posedge aclk); while (!s_ready);
    endtask

    // result side back-pressure
    initial begin
        int stall;
        @(posedge aclk iff aresetn);
        forever begin
            stall = quiet ? 0 : $urandom_range(0, 14);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    initial begin
        logic [skt_pkg::KEY_W-1:0] mask;
        logic [skt_pkg::KEY_W-1:0] k;
        skt_pkg::op_t              op;
        int                        r;
        int                        idx;
        int                        wait_cycles;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty table, extreme keys and payloads, shifts at both ends
        send_request(skt_pkg::OP_LOOKUP, 32'h0000_0000, rand_data());
        send_request(skt_pkg::OP_MODIFY, 32'h0000_0005, rand_data());
        send_request(skt_pkg::OP_DELETE, 32'h0000_0005, rand_data());
        send_request(skt_pkg::OP_INSERT, 32'h0000_0000, {skt_pkg::DATA_W{1'b1}});
        send_request(skt_pkg::OP_INSERT, 32'hFFFF_FFFF, {skt_pkg::DATA_W{1'b0}});
        send_request(skt_pkg::OP_INSERT, 32'h8000_0000, 64'hA5A5_A5A5_5A5A_5A5A);
        send_request(skt_pkg::OP_INSERT, 32'h7FFF_FFFF, rand_data());
        send_request(skt_pkg::OP_INSERT, 32'h0000_0000, rand_data());
        send_request(skt_pkg::OP_LOOKUP, 32'h0000_0000, rand_data());
        send_request(skt_pkg::OP_LOOKUP, 32'hFFFF_FFFF, rand_data());
        send_request(skt_pkg::OP_LOOKUP, 32'h0001_2345, rand_data());
        send_request(skt_pkg::OP_MODIFY, 32'h8000_0000, {skt_pkg::DATA_W{1'b1}});
        send_request(skt_pkg::OP_MODIFY, 32'h0000_0099, rand_data());
        send_request(skt_pkg::OP_LOOKUP, 32'h8000_0000, rand_data());
        send_request(skt_pkg::OP_DELETE, 32'h7FFF_FFFF, rand_data());
        send_request(skt_pkg::OP_DELETE, 32'h7FFF_FFFF, rand_data());
        send_request(skt_pkg::OP_LOOKUP, 32'hFFFF_FFFF, rand_data());
        send_request(skt_pkg::OP_DELETE, 32'h0000_0000, rand_data());
        send_request(skt_pkg::OP_DELETE, 32'hFFFF_FFFF, rand_data());
        send_request(skt_pkg::OP_LOOKUP, 32'h8000_0000, rand_data());
        send_request(skt_pkg::OP_INSERT, 32'h4000_0000, rand_data());
        send_request(skt_pkg::OP_DELETE, 32'h8000_0000, rand_data());
        send_request(skt_pkg::OP_DELETE, 32'h4000_0000, rand_data());

        // each epoch: fill past capacity, mixed traffic, then drain
        for (int ep = 0; ep < 5; ep++) begin
            mask = (ep == 0) ? 32'h0 : (ep == 1) ? 32'hFFFF_FFFF : $urandom;
            for (int seg = 0; seg < 3; seg++) begin
                quiet = ($urandom_range(0, 3) == 0);
                for (int n = 0; n < 120; n++) begin
                    r = $urandom_range(0, 99);
                    idx = $urandom_range(0, 79);
                    op = skt_pkg::op_t'($urandom_range(0, 3));
                    if (seg == 0 && r < 80) begin
                        op = skt_pkg::OP_INSERT;
                        if (r < 68) begin
                            idx = n % 80;
                        end
                    end else if (seg == 2 && r < 75) begin
                        op = skt_pkg::OP_DELETE;
                        idx = n % 80;
                    end
                    k = ($urandom_range(0, 99) < 8) ? $urandom : pool_key(idx, mask);
                    send_request(op, k, rand_data());
                end
            end
        end
        s_valid <= 1'b0;
        quiet = 1'b0;

        repeat (2) @(posedge aclk);
        wait_cycles = 0;
        while (awaiting_replies != 0 && wait_cycles < 20000) begin
            @(posedge aclk);
            wait_cycles++;
        end
        repeat (8) @(posedge aclk);
        if (fail_count == 0 && awaiting_replies == 0) begin
            $display("sorted_key_table_top test passed");
        end else begin
            $display("sorted_key_table_top test failed");
        end
        $finish;
    end

endmodule
